// File: src/dqs_pkg.sv
// Shared types and constants for the double-ended queue with search.
`default_nettype none
package dqs_pkg;

    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int OCC_W   = 7;

    typedef enum logic [MODE_W-1:0] {
        M_INS_FRONT = 3'd0,
        M_INS_BACK  = 3'd1,
        M_REM_FRONT = 3'd2,
        M_REM_BACK  = 3'd3,
        M_SEARCH    = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage
`default_nettype wire

// File: src/dqs_ring.sv
// Ring slot adder: (base + offset) modulo the ring depth.
`default_nettype none
module dqs_ring #(
    parameter int DEPTH = 64,
    parameter int PW    = 6,
    parameter int CW    = 7
) (
    input  wire logic [PW-1:0] i_base,
    input  wire logic [CW-1:0] i_offset,
    output logic      [PW-1:0] o_slot
);

    localparam int SW = ((PW > CW) ? PW : CW) + 1;
    localparam logic [SW-1:0] C_DEPTH = SW'(DEPTH);

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_wrap;

    // base < DEPTH and offset <= DEPTH, so one subtract folds the sum back
    assign w_sum  = SW'(i_base) + SW'(i_offset);
    assign w_wrap = (w_sum >= C_DEPTH) ? (w_sum - C_DEPTH) : w_sum;
    assign o_slot = w_wrap[PW-1:0];

endmodule
`default_nettype wire

// File: src/dqs_store.sv
// Entry store: single write port, single registered read port.
`default_nettype none
module dqs_store
    import dqs_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int PW    = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [PW-1:0]      i_waddr,
    input  wire logic [VALUE_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [PW-1:0]      i_raddr,
    output logic      [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: src/deque_with_search_core.sv
// Top level: double-ended queue of signed words with linear search.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | input     | i_valid / o_ready  | i_mode, i_value
//  out     | output    | o_valid / i_ready  | o_removed_value, o_status,
//          |           |                    | o_position, o_occupancy
//
//  Steps: an insert or an unused code goes from idle straight to the finish state;
//  a removal passes through the read-wait state (not on an empty list). A search
//  walks the entries from the front in the search state until a match or the last
//  entry; the single read port of the entry store delivers one entry per cycle to
//  the shared comparator.
//  Reset (synchronous, active low) empties the list; the store is not cleared.
//  One word is in work at a time; o_ready is high only in the idle state.
//  A finished result waits in the output register, and the next word is taken
//  while it waits; a new result stalls in the finish state until that
//  register is free.
`default_nettype none
module deque_with_search_core
    import dqs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic        [MODE_W-1:0]  i_mode,
    input  wire logic signed [VALUE_W-1:0] i_value,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic signed      [VALUE_W-1:0] o_removed_value,
    output logic             [STAT_W-1:0]  o_status,
    output logic             [POS_W-1:0]   o_position,
    output logic             [OCC_W-1:0]   o_occupancy
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PX = (PW > POS_W) ? PW : POS_W;
    localparam int OX = (CW > OCC_W) ? CW : OCC_W;

    localparam logic [PW-1:0] C_LAST = PW'(CAPACITY - 1);
    localparam logic [CW-1:0] C_FULL = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDWAIT,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    // list state
    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // search walk: slot of the next read and index of the entry now compared
    logic [PW-1:0]      r_slot, n_slot;
    logic [PW-1:0]      r_cidx, n_cidx;
    logic [VALUE_W-1:0] r_value, n_value;

    // pending result
    logic [VALUE_W-1:0] r_res_removed, n_res_removed;
    t_status            r_res_status, n_res_status;
    logic [PW-1:0]      r_res_pos, n_res_pos;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_removed, n_out_removed;
    t_status            r_out_status, n_out_status;
    logic [PW-1:0]      r_out_pos, n_out_pos;
    logic [CW-1:0]      r_out_occ, n_out_occ;

    // store port
    logic               w_we;
    logic [PW-1:0]      w_waddr;
    logic               w_re;
    logic [PW-1:0]      w_raddr;
    logic [VALUE_W-1:0] w_rdata;

    // ring arithmetic
    logic [CW-1:0] w_ring_off;
    logic [PW-1:0] w_ring_slot;
    logic [PW-1:0] w_front_dec;
    logic [PW-1:0] w_front_inc;
    logic [PW-1:0] w_slot_inc;
    logic          w_empty;
    logic          w_full;
    logic          w_match;
    logic          w_last;

    logic [PX-1:0] w_pos_ext;
    logic [OX-1:0] w_occ_ext;

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == C_FULL);
    assign w_front_dec = (r_front == '0) ? C_LAST : (r_front - 1'b1);
    assign w_front_inc = (r_front == C_LAST) ? '0 : (r_front + 1'b1);
    assign w_slot_inc  = (r_slot == C_LAST) ? '0 : (r_slot + 1'b1);

    // back removal reads the last entry, back insertion writes just past it
    assign w_ring_off = (t_mode'(i_mode) == M_REM_BACK) ? (r_count - 1'b1) : r_count;

    dqs_ring #(
        .DEPTH (CAPACITY),
        .PW    (PW),
        .CW    (CW)
    ) u_ring (
        .i_base   (r_front),
        .i_offset (w_ring_off),
        .o_slot   (w_ring_slot)
    );

    dqs_store #(
        .DEPTH (CAPACITY),
        .PW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared comparator and end-of-list check for the search walk
    assign w_match = (w_rdata == r_value);
    assign w_last  = (CW'(r_cidx) == (r_count - 1'b1));

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_slot        = r_slot;
        n_cidx        = r_cidx;
        n_value       = r_value;
        n_res_removed = r_res_removed;
        n_res_status  = r_res_status;
        n_res_pos     = r_res_pos;
        n_out_valid   = r_out_valid;
        n_out_removed = r_out_removed;
        n_out_status  = r_out_status;
        n_out_pos     = r_out_pos;
        n_out_occ     = r_out_occ;
        w_we          = 1'b0;
        w_waddr       = w_ring_slot;
        w_re          = 1'b0;
        w_raddr       = r_front;

        // drop the held result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value       = i_value;
                    n_res_removed = '0;
                    n_res_status  = ST_OK;
                    n_res_pos     = '0;
                    n_state       = S_FINISH;
                    case (t_mode'(i_mode))
                        M_INS_FRONT: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_front_dec;
                                n_front = w_front_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        M_INS_BACK: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_ring_slot;
                                n_count = r_count + 1'b1;
                            end
                        end
                        M_REM_FRONT: begin
                            if (w_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_front;
                                n_front = w_front_inc;
                                n_count = r_count - 1'b1;
                                n_state = S_RDWAIT;
                            end
                        end
                        M_REM_BACK: begin
                            if (w_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_ring_slot;
                                n_count = r_count - 1'b1;
                                n_state = S_RDWAIT;
                            end
                        end
                        M_SEARCH: begin
                            if (w_empty) begin
                                n_res_status = ST_NOTFOUND;
                            end else begin
                                // fetch the front entry, point at the next one
                                w_re    = 1'b1;
                                w_raddr = r_front;
                                n_slot  = w_front_inc;
                                n_cidx  = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            // unused mode: nothing changes
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_res_removed = w_rdata;
                n_state       = S_FINISH;
            end
            S_SEARCH: begin
                if (w_match) begin
                    n_res_pos = r_cidx;
                    n_state   = S_FINISH;
                end else if (w_last) begin
                    n_res_status = ST_NOTFOUND;
                    n_state      = S_FINISH;
                end else begin
                    // fetch the next entry while this one is compared
                    w_re    = 1'b1;
                    w_raddr = r_slot;
                    n_slot  = w_slot_inc;
                    n_cidx  = r_cidx + 1'b1;
                end
            end
            S_FINISH: begin
                // advance the result into the output register once it is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_removed = r_res_removed;
                    n_out_status  = r_res_status;
                    n_out_pos     = r_res_pos;
                    n_out_occ     = r_count;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_slot        <= n_slot;
        r_cidx        <= n_cidx;
        r_value       <= n_value;
        r_res_removed <= n_res_removed;
        r_res_status  <= n_res_status;
        r_res_pos     <= n_res_pos;
        r_out_removed <= n_out_removed;
        r_out_status  <= n_out_status;
        r_out_pos     <= n_out_pos;
        r_out_occ     <= n_out_occ;
    end

    // fit position and occupancy to the port widths
    assign w_pos_ext = PX'(r_out_pos);
    assign w_occ_ext = OX'(r_out_occ);

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_removed_value = r_out_removed;
    assign o_status        = r_out_status;
    assign o_position      = w_pos_ext[POS_W-1:0];
    assign o_occupancy     = w_occ_ext[OCC_W-1:0];

endmodule
`default_nettype wire

// File: sim/deque_checker.sv
`timescale 1ns / 1ps
// Result checker for the deque core: mirrors the list and compares every result word.
module deque_checker
    import dqs_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    input  wire logic        [MODE_W-1:0]  i_mode,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic signed [VALUE_W-1:0] i_removed_value,
    input  wire logic        [STAT_W-1:0]  i_status,
    input  wire logic        [POS_W-1:0]   i_position,
    input  wire logic        [OCC_W-1:0]   i_occupancy,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        t_status                   status;
        logic        [POS_W-1:0]   position;
        logic        [OCC_W-1:0]   occupancy;
    } t_deque_result;

    // Mirror of the list: ring slots, slot of the front entry, entries held.
    logic signed [VALUE_W-1:0] list_slots [CAPACITY];
    int front_slot = 0;
    int held_count = 0;

    t_deque_result expected_results [$];
    int mismatches = 0;

    task automatic apply_deque_op(input logic [MODE_W-1:0] mode,
                                  input logic signed [VALUE_W-1:0] value);
        t_deque_result r;
        bit hit;
        r = '0;
        r.status = ST_OK;
        hit = 1'b0;
        case (mode)
            M_INS_FRONT, M_INS_BACK: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (mode == M_INS_FRONT) begin
                    front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
                    list_slots[front_slot] = value;
                    held_count++;
                end else begin
                    list_slots[(front_slot + held_count) % CAPACITY] = value;
                    held_count++;
                end
            end
            M_REM_FRONT: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed_value = list_slots[front_slot];
                    front_slot = (front_slot + 1) % CAPACITY;
                    held_count--;
                end
            end
            M_REM_BACK: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed_value = list_slots[(front_slot + held_count - 1) % CAPACITY];
                    held_count--;
                end
            end
            M_SEARCH: begin
                // Walk from the front, last entry included; keep the first match.
                r.status = ST_NOTFOUND;
                for (int k = 0; k < held_count; k++) begin
                    if (!hit && list_slots[(front_slot + k) % CAPACITY] == value) begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.position = POS_W'(k);
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(held_count);
        expected_results.push_back(r);
    endtask

    task automatic compare_result();
        t_deque_result want;
        if (expected_results.size() == 0) begin
            $error("result word with nothing outstanding: status %0d, occupancy %0d",
                   i_status, i_occupancy);
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            if (i_removed_value !== want.removed_value) begin
                $error("removed_value: expected %0d, got %0d",
                       want.removed_value, i_removed_value);
                mismatches++;
            end
            if (i_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, i_status);
                mismatches++;
            end
            if (i_position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, i_position);
                mismatches++;
            end
            if (i_occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, i_occupancy);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot = 0;
            held_count = 0;
            expected_results.delete();
        end else begin
            // Results always belong to older words, so compare before predicting.
            if (i_out_valid && i_out_ready) compare_result();
            if (i_in_valid && i_in_ready) apply_deque_op(i_mode, i_value);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the deque core.
module tb_top;
    import dqs_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 100;   // covers the longest search after the last result
    localparam int PHASE_WORDS    = 150;
    localparam int FILL_WORDS     = 80;    // first part of each 150 words leans toward inserts
    localparam int BURST_WORDS    = 12;    // words offered while the receiver holds off

    localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      i_ready = 1'b0;
    logic        [MODE_W-1:0]  i_mode  = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_ready;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_removed_value;
    logic        [STAT_W-1:0]  o_status;
    logic        [POS_W-1:0]   o_position;
    logic        [OCC_W-1:0]   o_occupancy;

    int fail_count;
    int pending_count;

    // Idle rates in percent of cycles; the receiver one is sampled by its own process.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Hold-off handshake: stimulus bumps the request, the receiver serves it.
    int hold_req    = 0;
    int hold_served = 0;
    int hold_left   = 0;

    int quiet_cycles = 0;

    // Values reused often so that searches hit and duplicates show up.
    logic signed [VALUE_W-1:0] value_pool [16];
    logic signed [VALUE_W-1:0] recent_inserts [8];
    int recent_wr = 0;

    deque_with_search_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_occupancy    (o_occupancy)
    );

    deque_checker #(
        .CAPACITY(CAPACITY)
    ) result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_removed_value(o_removed_value),
        .i_status       (o_status),
        .i_position     (o_position),
        .i_occupancy    (o_occupancy),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: hold off for a long stretch on request, else drop ready at random.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_req) begin
            i_ready     <= 1'b0;
            hold_served <= hold_req;
            hold_left   <= HOLD_CYCLES - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word, hold it until taken, then maybe idle for a while.
    task automatic send_word(input logic [MODE_W-1:0] mode,
                             input logic signed [VALUE_W-1:0] value);
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] insert_value();
        if ($urandom_range(0, 99) < 40) return value_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic signed [VALUE_W-1:0] search_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return recent_inserts[$urandom_range(0, 7)];
        if (roll < 80) return value_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // One random word; filling leans toward inserts, draining toward removals.
    task automatic send_random_word(input bit filling);
        int roll;
        int ins_pct;
        int rem_pct;
        logic [MODE_W-1:0] mode;
        logic signed [VALUE_W-1:0] value;
        ins_pct = filling ? 82 : 4;
        rem_pct = filling ? 6 : 84;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            mode  = $urandom_range(0, 1) ? M_INS_BACK : M_INS_FRONT;
            value = insert_value();
            recent_inserts[recent_wr] = value;
            recent_wr = (recent_wr + 1) % 8;
        end else if (roll < ins_pct + rem_pct) begin
            mode  = $urandom_range(0, 1) ? M_REM_BACK : M_REM_FRONT;
            value = $urandom;
        end else if (roll < 98) begin
            mode  = M_SEARCH;
            value = search_value();
        end else begin
            // Codes past the last operation must leave the list alone.
            mode  = MODE_W'($urandom_range(int'(M_SEARCH) + 1, (1 << MODE_W) - 1));
            value = $urandom;
        end
        send_word(mode, value);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int words);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        for (int n = 0; n < words; n++) send_random_word((n % PHASE_WORDS) < FILL_WORDS);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_count == 0);
    endtask

    initial begin
        value_pool[0] = MOST_NEG;
        value_pool[1] = MOST_POS;
        value_pool[2] = '0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        for (int k = 5; k < 16; k++) value_pool[k] = $urandom;
        for (int k = 0; k < 8; k++) recent_inserts[k] = value_pool[k];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, unused codes, extremes, a search that misses over the whole list, duplicate search.
        send_idle_pct = 20;
        recv_idle_pct <= 20;
        send_word(M_SEARCH, 0);
        send_word(M_REM_FRONT, $urandom);
        send_word(M_REM_BACK, $urandom);
        for (int m = int'(M_SEARCH) + 1; m < (1 << MODE_W); m++) send_word(MODE_W'(m), $urandom);
        send_word(M_INS_FRONT, MOST_NEG);
        send_word(M_INS_BACK, MOST_POS);
        send_word(M_INS_FRONT, -1);
        send_word(M_INS_BACK, 0);
        send_word(M_SEARCH, MOST_POS);
        send_word(M_SEARCH, -1);
        send_word(M_SEARCH, MOST_NEG);
        send_word(M_SEARCH, 12345);
        send_word(M_INS_BACK, 0);
        send_word(M_SEARCH, 0);
        send_word(M_REM_BACK, $urandom);
        send_word(M_REM_FRONT, $urandom);
        send_word(M_REM_BACK, $urandom);
        send_word(M_REM_FRONT, $urandom);
        send_word(M_REM_BACK, $urandom);

        // Random: receiver idles more, then sender idles more.
        run_phase(31, 64, PHASE_WORDS);
        drain_results();
        run_phase(64, 31, PHASE_WORDS);

        // No idling; first hold the receiver off while words keep coming.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req <= hold_req + 1;
        for (int n = 0; n < BURST_WORDS; n++) send_random_word(1'b1);
        run_phase(0, 0, PHASE_WORDS - BURST_WORDS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
